// ----- rtl/modrtu_pkg.sv -----
`default_nettype none

package modrtu_pkg;

   // action codes carried with each input transaction
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_GAP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_GAP   = 2'd1;

   // gap timer reset values (1.5 and 3.5 character times)
   localparam logic [15:0] SHORT_GAP_RESET = 16'd3468;
   localparam logic [15:0] END_GAP_RESET   = 16'd8092;

   // reflected CRC-16
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // gap count saturates here; a good frame shows exactly GAPS_EXPECTED
   localparam logic [1:0] GAP_COUNT_MAX = 2'd3;
   localparam logic [1:0] GAPS_EXPECTED = 2'd2;

   typedef struct packed {
      logic [15:0] short_gap_ticks;
      logic [15:0] end_gap_ticks;
   } gap_cfg_type;

   typedef struct packed {
      logic [3:0] frame_length;
      logic       crc_ok;
      logic       gaps_ok;
      logic       overflowed;
   } frame_result_type;

   // fold one byte into the running CRC, LSB first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/modrtu_frame_state.sv -----
`default_nettype none

module modrtu_frame_state
   import modrtu_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic             action,
   input  wire logic [7:0]       rx_byte,
   input  wire gap_cfg_type      gap_cfg,
   output logic                  frame_end,
   output frame_result_type      result
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_MIN_CRC = CNT_W'(3);

   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      short_timer_ff, short_timer_in;
   logic [15:0]      end_timer_ff, end_timer_in;
   logic [1:0]       gap_count_ff, gap_count_in;
   logic             running_ff, running_in;
   logic             overflow_ff, overflow_in;

   logic [15:0] short_inc;
   logic [15:0] end_inc;
   logic        short_hit;
   logic        end_hit;
   logic [1:0]  gap_bumped;

   // tick evaluation; stored timer values stay below their limits, so +1 fits
   always_comb begin
      short_inc  = short_timer_ff + 16'd1;
      end_inc    = end_timer_ff + 16'd1;
      short_hit  = short_inc >= gap_cfg.short_gap_ticks;
      end_hit    = end_inc >= gap_cfg.end_gap_ticks;
      gap_bumped = (short_hit && gap_count_ff != GAP_COUNT_MAX) ?
                   gap_count_ff + 2'd1 : gap_count_ff;
      frame_end  = (action == ACTION_TICK) && running_ff && end_hit;
   end

   // result of the frame that this tick closes
   always_comb begin
      result.frame_length = 4'(count_ff);
      result.crc_ok       = (crc_ff == 16'h0000) && (count_ff >= CNT_MIN_CRC) && !overflow_ff;
      result.gaps_ok      = gap_bumped == GAPS_EXPECTED;
      result.overflowed   = overflow_ff;
   end

   // next frame state
   always_comb begin
      crc_in         = crc_ff;
      count_in       = count_ff;
      short_timer_in = short_timer_ff;
      end_timer_in   = end_timer_ff;
      gap_count_in   = gap_count_ff;
      running_in     = running_ff;
      overflow_in    = overflow_ff;
      if (go) begin
         if (action == ACTION_BYTE) begin
            short_timer_in = 16'd0;
            end_timer_in   = 16'd0;
            running_in     = 1'b1;
            if (count_ff < CNT_LIMIT) begin
               count_in = count_ff + CNT_W'(1);
               crc_in   = crc_fold(crc_ff, rx_byte);
            end else begin
               overflow_in = 1'b1;
            end
         end else if (running_ff) begin
            if (end_hit) begin
               // end of frame: back to idle
               crc_in         = CRC_SEED;
               count_in       = '0;
               short_timer_in = 16'd0;
               end_timer_in   = 16'd0;
               gap_count_in   = 2'd0;
               running_in     = 1'b0;
               overflow_in    = 1'b0;
            end else begin
               short_timer_in = short_hit ? 16'd0 : short_inc;
               gap_count_in   = gap_bumped;
               end_timer_in   = end_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff         <= CRC_SEED;
         count_ff       <= '0;
         short_timer_ff <= 16'd0;
         end_timer_ff   <= 16'd0;
         gap_count_ff   <= 2'd0;
         running_ff     <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         crc_ff         <= crc_in;
         count_ff       <= count_in;
         short_timer_ff <= short_timer_in;
         end_timer_ff   <= end_timer_in;
         gap_count_ff   <= gap_count_in;
         running_ff     <= running_in;
         overflow_ff    <= overflow_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_frame_receiver.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_action, req_rx_byte
// rsp      out        rsp_valid / rsp_ready  rsp_frame_length, rsp_crc_ok, rsp_gaps_ok,
//                                            rsp_overflowed
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One transaction per cycle unless req stalls: an input register feeds the frame state logic
// (CRC fold and gap timers), which loads the result register at end of frame. An accepted
// closing tick passes the input register and then the result register before rsp_valid rises.
// Synchronous reset clears frame state and loads the default gap limits.
// req stalls only when a closing tick meets a full result register; csr_ready is
// always high.

module modbus_rtu_frame_receiver
   import modrtu_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [3:0]                  rsp_frame_length,
   output logic                        rsp_crc_ok,
   output logic                        rsp_gaps_ok,
   output logic                        rsp_overflowed,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_data
);

   gap_cfg_type      gap_cfg_ff, gap_cfg_in;
   logic             stage_valid_ff, stage_valid_in;
   logic             stage_action_ff;
   logic [7:0]       stage_byte_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   frame_result_type rsp_result_ff;

   logic             frame_end;
   frame_result_type frame_result;
   logic             out_free;
   logic             advance;
   logic             req_take;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      gap_cfg_in = gap_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHORT_GAP: gap_cfg_in.short_gap_ticks = csr_data;
            CSR_END_GAP:   gap_cfg_in.end_gap_ticks   = csr_data;
            default:       gap_cfg_in = gap_cfg_ff;
         endcase
      end
   end

   // handshake between input register, state logic and result register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = stage_valid_ff && (!frame_end || out_free);
   assign req_ready = !stage_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   modrtu_frame_state #(
      .MAX_FRAME(MAX_FRAME)
   ) u_frame_state (
      .clock    (clock),
      .reset    (reset),
      .go       (advance),
      .action   (stage_action_ff),
      .rx_byte  (stage_byte_ff),
      .gap_cfg  (gap_cfg_ff),
      .frame_end(frame_end),
      .result   (frame_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_cfg_ff.short_gap_ticks <= SHORT_GAP_RESET;
         gap_cfg_ff.end_gap_ticks   <= END_GAP_RESET;
         stage_valid_ff             <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         gap_cfg_ff     <= gap_cfg_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_action_ff <= req_action;
         stage_byte_ff   <= req_rx_byte;
      end
      if (advance && frame_end) begin
         rsp_result_ff <= frame_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_length = rsp_result_ff.frame_length;
   assign rsp_crc_ok       = rsp_result_ff.crc_ok;
   assign rsp_gaps_ok      = rsp_result_ff.gaps_ok;
   assign rsp_overflowed   = rsp_result_ff.overflowed;

   // input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   // a good CRC is never reported for an overflowed frame
   a_crc_vs_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_crc_ok && rsp_overflowed))
      else $error("crc_ok reported on an overflowed frame");

   // overflow means the buffer was full
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_frame_length == 4'(MAX_FRAME))
      else $error("overflow reported with a partly filled buffer");

endmodule

`default_nettype wire

// ----- verif/modbus_rtu_frame_receiver_tb.sv -----
`timescale 1ns / 100ps

module modbus_rtu_frame_receiver_tb;
   import modrtu_pkg::*;

   localparam int unsigned FRAME_CAPACITY = 8;
   localparam int unsigned MIN_CRC_BYTES  = 3;
   localparam int unsigned RANDOM_ITEMS   = 1400;
   localparam int unsigned RANDOM_PHASES  = 7;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned PROBE_TICKS    = 200;
   localparam int unsigned CYCLE_LIMIT    = 1_000_000;

   // register indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_action = ACTION_TICK;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [3:0]             rsp_frame_length;
   logic                   rsp_crc_ok;
   logic                   rsp_gaps_ok;
   logic                   rsp_overflowed;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SHORT_GAP;
   logic [15:0]            csr_data = 16'h0000;

   modbus_rtu_frame_receiver #(
      .MAX_FRAME (FRAME_CAPACITY)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_length (rsp_frame_length),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_gaps_ok      (rsp_gaps_ok),
      .rsp_overflowed   (rsp_overflowed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mirror of the receiver: gap limits and the frame in progress
   logic [15:0] cfg_char_gap;
   logic [15:0] cfg_frame_gap;
   logic [15:0] crc_acc;
   logic [3:0]  stored_count;
   logic [15:0] char_gap_cnt;
   logic [15:0] frame_end_cnt;
   logic [1:0]  short_expiries;
   logic        frame_open;
   logic        bytes_dropped;

   frame_result_type pending_frame_reports[$];
   logic [7:0]       frame_bytes[$];

   int unsigned items_sent;
   int unsigned fail_count;
   int unsigned cycle_count;
   bit          burst_mode;
   logic        start_hold = 1'b0;

   function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = {acc[15:8], acc[7:0] ^ data};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void frame_clear();
      crc_acc        = CRC_SEED;
      stored_count   = '0;
      char_gap_cnt   = '0;
      frame_end_cnt  = '0;
      short_expiries = '0;
      frame_open     = 1'b0;
      bytes_dropped  = 1'b0;
   endfunction

   // advance the frame by one accepted transaction; 1 when a frame report is due
   function automatic bit frame_advance(input logic act, input logic [7:0] data,
                                        output frame_result_type report);
      report = '0;
      if (act == ACTION_BYTE) begin
         char_gap_cnt  = '0;
         frame_end_cnt = '0;
         frame_open    = 1'b1;
         if (stored_count < FRAME_CAPACITY) begin
            stored_count++;
            crc_acc = crc16_fold(crc_acc, data);
         end else begin
            bytes_dropped = 1'b1;
         end
         return 1'b0;
      end
      if (!frame_open) return 1'b0;
      // short timer first, then the end of frame timer
      char_gap_cnt++;
      if (char_gap_cnt >= cfg_char_gap) begin
         char_gap_cnt = '0;
         if (short_expiries != GAP_COUNT_MAX) short_expiries++;
      end
      frame_end_cnt++;
      if (frame_end_cnt >= cfg_frame_gap) begin
         report.frame_length = stored_count;
         report.crc_ok       = (crc_acc == 16'h0000) && (stored_count >= MIN_CRC_BYTES) &&
                               !bytes_dropped;
         report.gaps_ok      = (short_expiries == GAPS_EXPECTED);
         report.overflowed   = bytes_dropped;
         frame_clear();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // one input transaction, with a random idle gap in front unless bursting
   task automatic send_item(input logic act, input logic [7:0] data);
      int unsigned gap;
      int unsigned pick;
      frame_result_type report;
      gap = 0;
      if (!burst_mode) begin
         pick = $urandom_range(99);
         if (pick < 55) gap = 0;
         else if (pick < 92) gap = $urandom_range(3, 1);
         else gap = $urandom_range(40, 8);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // ticks while idle are ignored by the block
      if (act == ACTION_BYTE || frame_open) items_sent++;
      if (frame_advance(act, data, report)) pending_frame_reports.push_back(report);
   endtask

   task automatic send_tick();
      send_item(ACTION_TICK, 8'($urandom_range(255)));
   endtask

   task automatic close_frame();
      while (frame_open) send_tick();
   endtask

   // random payload, optionally followed by its CRC (low byte first)
   task automatic build_frame(input int unsigned n_data, input bit add_crc);
      logic [15:0] c;
      logic [7:0]  b;
      frame_bytes.delete();
      c = CRC_SEED;
      repeat (n_data) begin
         b = 8'($urandom_range(255));
         frame_bytes.push_back(b);
         c = crc16_fold(c, b);
      end
      if (add_crc) begin
         frame_bytes.push_back(c[7:0]);
         frame_bytes.push_back(c[15:8]);
      end
   endtask

   task automatic corrupt_frame();
      int unsigned idx;
      idx = $urandom_range(frame_bytes.size() - 1);
      frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
   endtask

   // send frame_bytes with a few ticks between characters, then let it time out
   task automatic send_frame(input int unsigned intra_lo, input int unsigned intra_hi);
      for (int i = 0; i < frame_bytes.size(); i++) begin
         if (i != 0) repeat ($urandom_range(intra_hi, intra_lo)) send_tick();
         send_item(ACTION_BYTE, frame_bytes[i]);
      end
      close_frame();
   endtask

   task automatic wait_drained();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (pending_frame_reports.size() != 0) @(posedge clock);
   endtask

   // register writes only once the pipeline is empty
   task automatic write_gap_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SHORT_GAP) cfg_char_gap = value;
      else if (idx == CSR_END_GAP) cfg_frame_gap = value;
   endtask

   task automatic set_gaps(input logic [15:0] short_ticks, input logic [15:0] end_ticks);
      write_gap_reg(CSR_SHORT_GAP, short_ticks);
      write_gap_reg(CSR_END_GAP, end_ticks);
   endtask

   // default limits straight out of reset: no end of frame and no short expiry
   // within the probe, then a shorter end limit closes the frame
   task automatic test_reset_defaults();
      repeat (3) send_tick();
      build_frame(2, 1'b1);
      foreach (frame_bytes[i]) send_item(ACTION_BYTE, frame_bytes[i]);
      burst_mode = 1'b1;
      repeat (PROBE_TICKS) send_tick();
      burst_mode = 1'b0;
      write_gap_reg(CSR_END_GAP, 16'(PROBE_TICKS + 10));
      close_frame();
   endtask

   task automatic test_crc_and_length();
      set_gaps(16'd2, 16'd5);
      // lone zero byte: too short for a CRC
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      send_frame(0, 0);
      // FF FF leaves a zero residue but is still below the minimum length
      build_frame(0, 1'b1);
      send_frame(0, 0);
      build_frame(1, 1'b1);
      send_frame(0, 1);
      // buffer exactly full
      build_frame(6, 1'b1);
      send_frame(0, 1);
      build_frame(4, 1'b1);
      corrupt_frame();
      send_frame(0, 0);
      // two extra bytes are dropped
      build_frame(6, 1'b1);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
      send_frame(0, 1);
   endtask

   task automatic test_gap_counting();
      set_gaps(16'd2, 16'd5);
      build_frame(1, 1'b1);
      send_frame(2, 2);
      // four intra-frame expiries must saturate, not wrap
      build_frame(3, 1'b1);
      send_frame(2, 2);
      repeat (2) send_tick();
   endtask

   task automatic test_zero_and_spare_regs();
      write_gap_reg(CSR_SHORT_GAP, 16'd0);
      build_frame(1, 1'b1);
      send_frame(0, 0);
      write_gap_reg(CSR_END_GAP, 16'd0);
      build_frame(2, 1'b1);
      send_frame(0, 0);
      // undecoded indexes leave both limits alone
      write_gap_reg(CSR_SPARE_A, 16'd2);
      write_gap_reg(CSR_SPARE_B, 16'hFFFF);
      build_frame(1, 1'b1);
      send_frame(0, 0);
   endtask

   task automatic test_midframe_write();
      set_gaps(16'd2, 16'd5);
      send_item(ACTION_BYTE, 8'h5A);
      send_tick();
      send_tick();
      // new end limit applies at the next tick
      write_gap_reg(CSR_END_GAP, 16'd2);
      close_frame();
   endtask

   task automatic test_extreme_limits();
      set_gaps(16'hFFFF, 16'd12);
      build_frame(1, 1'b0);
      send_frame(0, 0);
      burst_mode = 1'b1;
      close_frame();
      burst_mode = 1'b0;
      write_gap_reg(CSR_END_GAP, 16'd1);
      build_frame(2, 1'b1);
      send_frame(0, 0);
      set_gaps(16'd1, 16'd2);
      build_frame(3, 1'b1);
      send_frame(0, 0);
   endtask

   // result side holds off while one-character frames keep coming
   task automatic test_backpressure();
      set_gaps(16'd1, 16'd1);
      start_hold <= 1'b1;
      @(posedge clock);
      start_hold <= 1'b0;
      burst_mode = 1'b1;
      repeat (80) begin
         send_item(ACTION_BYTE, 8'($urandom_range(255)));
         close_frame();
      end
      burst_mode = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned phase_start;
      int unsigned pick;
      int unsigned intra_hi;
      logic [15:0] short_ticks;
      logic [15:0] end_ticks;
      for (int s = 0; s < RANDOM_PHASES; s++) begin
         case (s)
            0: begin short_ticks = 16'd1; end_ticks = 16'd1; end
            1: begin short_ticks = 16'd1; end_ticks = 16'd2; end
            2: begin short_ticks = 16'd2; end_ticks = 16'd5; end
            3: begin short_ticks = 16'd3; end_ticks = 16'd8; end
            4: begin short_ticks = 16'd4; end_ticks = 16'd11; end
            5: begin short_ticks = 16'd5; end_ticks = 16'd14; end
            default: begin
               short_ticks = 16'($urandom_range(6, 1));
               end_ticks   = 16'($urandom_range(20, 1));
            end
         endcase
         set_gaps(short_ticks, end_ticks);
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
            burst_mode = ($urandom_range(9) == 0);
            intra_hi = (short_ticks > 1) ? short_ticks - 1 : 0;
            if ($urandom_range(9) == 0) intra_hi = (end_ticks > 1) ? end_ticks - 1 : 0;
            pick = $urandom_range(99);
            if (pick < 70) begin
               build_frame($urandom_range(6, 1), 1'b1);
               send_frame(0, intra_hi);
            end else if (pick < 78) begin
               build_frame($urandom_range(10, 7), 1'($urandom_range(1)));
               send_frame(0, intra_hi);
            end else if (pick < 86) begin
               build_frame($urandom_range(6, 1), 1'b1);
               corrupt_frame();
               send_frame(0, intra_hi);
            end else if (pick < 94) begin
               build_frame($urandom_range(4, 1), 1'b0);
               send_frame(0, intra_hi);
            end else begin
               repeat ($urandom_range(4, 1)) send_tick();
            end
            if ($urandom_range(7) == 0) wait_drained();
         end
         burst_mode = 1'b0;
      end
   endtask

   // result-side ready: random stalls, free-running stretches, one long hold
   int unsigned hold_left;
   int unsigned stall_left;
   int unsigned free_left;
   int unsigned ready_pick;

   always @(posedge clock) begin
      if (start_hold) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (free_left != 0) begin
         free_left--;
         rsp_ready <= 1'b1;
      end else begin
         ready_pick = $urandom_range(99);
         if (ready_pick < 3) begin
            free_left = $urandom_range(200, 50);
            rsp_ready <= 1'b1;
         end else if (ready_pick < 70) begin
            rsp_ready <= 1'b1;
         end else if (ready_pick < 95) begin
            stall_left = $urandom_range(2);
            rsp_ready <= 1'b0;
         end else begin
            stall_left = $urandom_range(40, 8);
            rsp_ready <= 1'b0;
         end
      end
   end

   // compare each accepted frame report with the oldest prediction
   frame_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frame_reports.size() == 0) begin
            $error("frame report with none expected: length %0d", rsp_frame_length);
            fail_count++;
         end else begin
            want = pending_frame_reports.pop_front();
            if (rsp_frame_length !== want.frame_length) begin
               $error("frame_length mismatch: expected %0d, actual %0d",
                      want.frame_length, rsp_frame_length);
               fail_count++;
            end
            if (rsp_crc_ok !== want.crc_ok) begin
               $error("crc_ok mismatch: expected %0b, actual %0b", want.crc_ok, rsp_crc_ok);
               fail_count++;
            end
            if (rsp_gaps_ok !== want.gaps_ok) begin
               $error("gaps_ok mismatch: expected %0b, actual %0b", want.gaps_ok, rsp_gaps_ok);
               fail_count++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed mismatch: expected %0b, actual %0b",
                      want.overflowed, rsp_overflowed);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("modbus_rtu_frame_receiver test failed");
         $finish;
      end
   end

   initial begin
      cfg_char_gap  = SHORT_GAP_RESET;
      cfg_frame_gap = END_GAP_RESET;
      frame_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_crc_and_length();
      test_gap_counting();
      test_zero_and_spare_regs();
      test_midframe_write();
      test_extreme_limits();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("modbus_rtu_frame_receiver test passed");
      end else begin
         $display("modbus_rtu_frame_receiver test failed");
      end
      $finish;
   end

endmodule
